[sv/ctst_pkg.sv]
// Shared types and constants for the complete tree slot table.
package ctst_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CHECK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_SIDE_TAKEN = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_INSERT = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DEL_RD = 7'b0001000,
    ST_DEL_WR = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic insert;
    logic scan;
    logic read_last;
    logic del_write;
    logic check;
    logic load_out;
  } ctst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_delete;
    logic scan_end;
    logic match;
    logic check_end;
  } ctst_sts_t;

endpackage

[sv/ctst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ctst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ctst_ctrl.sv]
// Sequencing state machine for the slot table actions.
module ctst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctst_pkg::action_e   action_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctst_pkg::ctst_cmd_t cmd_o,
  input  ctst_pkg::ctst_sts_t sts_i
);

  ctst_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ctst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (action_i)
            ctst_pkg::ACT_INSERT: state_d = ctst_pkg::ST_INSERT;
            ctst_pkg::ACT_DELETE,
            ctst_pkg::ACT_SEARCH: state_d = ctst_pkg::ST_SCAN;
            ctst_pkg::ACT_CHECK:  state_d = ctst_pkg::ST_CHECK;
            default:              state_d = ctst_pkg::ST_IDLE;
          endcase
        end
      end
      ctst_pkg::ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = ctst_pkg::ST_DONE;
      end
      ctst_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = (sts_i.match && sts_i.is_delete) ? ctst_pkg::ST_DEL_RD
                                                     : ctst_pkg::ST_DONE;
        end
      end
      ctst_pkg::ST_DEL_RD: begin
        cmd_o.read_last = 1'b1;
        state_d         = ctst_pkg::ST_DEL_WR;
      end
      ctst_pkg::ST_DEL_WR: begin
        cmd_o.del_write = 1'b1;
        state_d         = ctst_pkg::ST_DONE;
      end
      ctst_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.check_end) begin
          state_d = ctst_pkg::ST_DONE;
        end
      end
      ctst_pkg::ST_DONE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ctst_pkg::ST_IDLE;
        end
      end
      default: state_d = ctst_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ctst_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/ctst_dp.sv]
// Datapath: request registers, count, attach flags, scan pointer and results.
module ctst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctst_pkg::ctst_cmd_t                 cmd_i,
  output ctst_pkg::ctst_sts_t                 sts_o,
  input  ctst_pkg::action_e                   action_i,
  input  logic [ctst_pkg::VALUE_W-1:0]        value_i,
  input  logic                                side_i,
  output logic                                ram_we_o,
  output logic [ctst_pkg::IDX_W-1:0]          ram_waddr_o,
  output logic [ctst_pkg::VALUE_W-1:0]        ram_wdata_o,
  output logic [ctst_pkg::IDX_W-1:0]          ram_raddr_o,
  input  logic [ctst_pkg::VALUE_W-1:0]        ram_rdata_i,
  output logic                                answer_o,
  output ctst_pkg::status_e                   status_o,
  output logic [ctst_pkg::COUNT_OUT_W-1:0]    entry_count_o
);

  localparam int unsigned IW = ctst_pkg::IDX_W;
  localparam int unsigned CW = ctst_pkg::CNT_W;

  // request payload
  ctst_pkg::action_e             action_q;
  logic [ctst_pkg::VALUE_W-1:0]  value_q;
  logic                          side_q;

  // control state
  logic [CW-1:0]                 count_q, count_d;
  logic [ctst_pkg::DEPTH-1:0]    left_q, left_d, right_q, right_d;
  logic [CW-1:0]                 scan_q, scan_d;
  logic                          pend_q, pend_d;
  logic [IW-1:0]                 pend_idx_q, pend_idx_d;
  logic [IW-1:0]                 hit_idx_q, hit_idx_d;

  // staged and delivered result
  logic                          res_ans_q, res_ans_d;
  ctst_pkg::status_e             res_sts_q, res_sts_d;
  logic                          out_ans_q;
  ctst_pkg::status_e             out_sts_q;
  logic [ctst_pkg::COUNT_OUT_W-1:0] out_cnt_q;

  logic          issue;
  logic          match;
  logic [CW-1:0] last;
  logic [IW-1:0] last_parent;
  logic [IW-1:0] ins_idx;
  logic [IW-1:0] ins_parent;
  logic          ins_flag;
  logic [IW-1:0] chk_idx;
  logic [CW:0]   chk_left_child;
  logic          chk_fail;

  assign issue       = (scan_q < count_q);
  assign match       = pend_q && (ram_rdata_i == value_q);
  assign last        = count_q - CW'(1);
  assign last_parent = IW'((last - CW'(1)) >> 1);
  assign ins_idx     = count_q[IW-1:0];
  assign ins_parent  = IW'((count_q - CW'(1)) >> 1);
  assign ins_flag    = side_q ? right_q[ins_parent] : left_q[ins_parent];
  assign chk_idx     = scan_q[IW-1:0];
  assign chk_left_child = {scan_q, 1'b1};
  assign chk_fail    = (right_q[chk_idx] && !left_q[chk_idx])
                    || ((chk_left_child < {1'b0, count_q}) && !left_q[chk_idx])
                    || (((chk_left_child + (CW+1)'(1)) < {1'b0, count_q})
                        && !right_q[chk_idx]);

  always_comb begin
    count_d    = count_q;
    left_d     = left_q;
    right_d    = right_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    hit_idx_d  = hit_idx_q;
    res_ans_d  = res_ans_q;
    res_sts_d  = res_sts_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ins_idx;
    ram_wdata_o = value_q;
    ram_raddr_o = scan_q[IW-1:0];
    sts_o.is_delete = (action_q == ctst_pkg::ACT_DELETE);
    sts_o.match     = match;
    sts_o.scan_end  = match || (!pend_q && !issue);
    sts_o.check_end = !issue || chk_fail;

    if (cmd_i.accept) begin
      scan_d = '0;
      pend_d = 1'b0;
    end

    if (cmd_i.insert) begin
      if (count_q == CW'(ctst_pkg::DEPTH)) begin
        res_ans_d = 1'b0;
        res_sts_d = ctst_pkg::STS_FULL;
      end else begin
        ram_we_o         = 1'b1;
        left_d[ins_idx]  = 1'b0;
        right_d[ins_idx] = 1'b0;
        if (count_q == '0) begin
          count_d   = CW'(1);
          res_ans_d = 1'b1;
          res_sts_d = ctst_pkg::STS_OK;
        end else if (!ins_flag) begin
          if (side_q) begin
            right_d[ins_parent] = 1'b1;
          end else begin
            left_d[ins_parent] = 1'b1;
          end
          count_d   = count_q + CW'(1);
          res_ans_d = 1'b1;
          res_sts_d = ctst_pkg::STS_OK;
        end else begin
          res_ans_d = 1'b0;
          res_sts_d = ctst_pkg::STS_SIDE_TAKEN;
        end
      end
    end

    if (cmd_i.scan) begin
      // one read issued per cycle, compared the cycle after
      pend_d     = issue;
      pend_idx_d = scan_q[IW-1:0];
      if (issue) begin
        scan_d = scan_q + CW'(1);
      end
      if (match) begin
        hit_idx_d = pend_idx_q;
      end
      if (sts_o.scan_end) begin
        res_ans_d = match;
        res_sts_d = match ? ctst_pkg::STS_OK : ctst_pkg::STS_NOT_FOUND;
      end
    end

    if (cmd_i.read_last) begin
      ram_raddr_o = last[IW-1:0];
    end

    if (cmd_i.del_write) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = hit_idx_q;
      ram_wdata_o = ram_rdata_i;
      if (last != '0) begin
        if (last[0]) begin
          left_d[last_parent] = 1'b0;
        end else begin
          right_d[last_parent] = 1'b0;
        end
      end
      count_d = last;
    end

    if (cmd_i.check) begin
      if (!issue) begin
        res_ans_d = 1'b1;
        res_sts_d = ctst_pkg::STS_OK;
      end else if (chk_fail) begin
        res_ans_d = 1'b0;
        res_sts_d = ctst_pkg::STS_OK;
      end else begin
        scan_d = scan_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      right_q <= right_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      value_q  <= value_i;
      side_q   <= side_i;
    end
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    res_ans_q  <= res_ans_d;
    res_sts_q  <= res_sts_d;
    if (cmd_i.load_out) begin
      out_ans_q <= res_ans_q;
      out_sts_q <= res_sts_q;
      out_cnt_q <= ctst_pkg::COUNT_OUT_W'(count_q);
    end
  end

  assign answer_o      = out_ans_q;
  assign status_o      = out_sts_q;
  assign entry_count_o = out_cnt_q;

endmodule

[sv/complete_tree_slot_table.sv]
// Top level: array-ordered binary tree table with insert, delete, search and check.
// A search scans the stored slots in order and stops at the first hit; a delete on a hit
// then reads the last slot and moves it into the hit slot. A check walks the slots and
// stops at the first slot that fails. One request in flight: the next is taken once the
// result is offered, and a result left waiting in the output register holds the following
// one back. Reset clears the count, all attach flags and the handshake.
module complete_tree_slot_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ctst_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] item_value, [32] side
  input  logic [ctst_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [1:0] action
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ctst_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // [0] answer, [2:1] status,
                                                            // [9:3] entry_count
);

  ctst_pkg::ctst_cmd_t cmd;
  ctst_pkg::ctst_sts_t sts;
  ctst_pkg::action_e   action;

  logic                              ram_we;
  logic [ctst_pkg::IDX_W-1:0]        ram_waddr;
  logic [ctst_pkg::VALUE_W-1:0]      ram_wdata;
  logic [ctst_pkg::IDX_W-1:0]        ram_raddr;
  logic [ctst_pkg::VALUE_W-1:0]      ram_rdata;

  logic                              answer;
  ctst_pkg::status_e                 status;
  logic [ctst_pkg::COUNT_OUT_W-1:0]  entry_count;

  // the action selects the sequence the controller runs
  assign action = ctst_pkg::action_e'(s_axis_tuser);

  ctst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (action),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ctst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action),
    .value_i       (s_axis_tdata[ctst_pkg::VALUE_W-1:0]),
    .side_i        (s_axis_tdata[ctst_pkg::VALUE_W]),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .answer_o      (answer),
    .status_o      (status),
    .entry_count_o (entry_count)
  );

  // slot values: written by insert and by the delete move, read by the scans
  ctst_ram #(
    .WIDTH (ctst_pkg::VALUE_W),
    .DEPTH (ctst_pkg::DEPTH)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // pack the result, zero-filled to whole bytes
  assign m_axis_tdata = {
    (ctst_pkg::OUT_DATA_W - ctst_pkg::COUNT_OUT_W - 3)'(0),
    entry_count,
    status,
    answer
  };

endmodule
